// ===== rtl/core/wifi_tx_airtime_duration_assert.svh =====
// assertion macros for the airtime duration block
`ifndef WIFI_TX_AIRTIME_DURATION_ASSERT_SVH
`define WIFI_TX_AIRTIME_DURATION_ASSERT_SVH
`ifndef SYNTH
// property checked outside of reset
`define WTAD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("wtad assertion failed");
// property checked at every edge, reset included
`define WTAD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("wtad assertion failed");
`else
`define WTAD_ASSERT(lbl, clk, rstn, prop)
`define WTAD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/wtad_pkg.sv =====
package wtad_pkg;

  // divider geometry
  localparam int NUM_W      = 25;
  localparam int DEN_W      = 16;
  localparam int DIV_STAGES = NUM_W;
  localparam int TIME_W     = 28;

  localparam logic [11:0] MAX_FRAME_BYTES = 12'd4095;

  // phy codes
  localparam logic [1:0] PHY_CCK   = 2'd0;
  localparam logic [1:0] PHY_OFDM  = 2'd1;
  localparam logic [1:0] PHY_HT    = 2'd2;
  localparam logic [1:0] PHY_RSVD  = 2'd3;
  localparam logic       CTRL_CCK  = 1'b0;
  localparam logic       CTRL_OFDM = 1'b1;

  // timing constants in us or bits
  localparam int CCK_GAP_US    = 10;
  localparam int CCK_PRE_BITS  = 144;
  localparam int CCK_HDR_BITS  = 48;
  localparam int OFDM_GAP_US   = 16;
  localparam int OFDM_PRE      = 20;
  localparam int OFDM_SVC_BITS = 22;
  localparam int HT_PRE        = 8 + 8 + 4 + 8 + 4 + 4 + 6;
  localparam int HT_SIFS       = 10;
  localparam int ACK_BYTES     = 14;
  localparam int RTS_BYTES     = 20;
  localparam int KBPS_SCALE    = 1000;

  localparam int CCK_LONG_OVH  = CCK_GAP_US + CCK_PRE_BITS + CCK_HDR_BITS;
  localparam int CCK_SHORT_OVH = CCK_GAP_US + (CCK_PRE_BITS + CCK_HDR_BITS) / 2;
  localparam int OFDM_OVH      = OFDM_GAP_US + OFDM_PRE;
  localparam int HT_OVH        = HT_PRE + HT_SIFS;
  localparam int ACK_BITS      = ACK_BYTES * 8;
  localparam int RTS_BITS      = RTS_BYTES * 8;
  // lsig: subtract sifs and 26, add 3 for rounding
  localparam int LSIG_OFS      = HT_SIFS + 26 - 3;

  // reciprocals: x/250 and x/5
  localparam logic [16:0] RECIP_250   = 17'd67109;
  localparam int          RECIP_250_S = 24;
  localparam logic [14:0] RECIP_5     = 15'd26215;
  localparam int          RECIP_5_S   = 17;

  function automatic logic [8:0] ht_dbps(logic [2:0] mcs);
    logic [8:0] r;
    unique case (mcs)
      3'd0: r = 9'd26;
      3'd1: r = 9'd52;
      3'd2: r = 9'd78;
      3'd3: r = 9'd104;
      3'd4: r = 9'd156;
      3'd5: r = 9'd208;
      3'd6: r = 9'd234;
      default: r = 9'd260;
    endcase
    return r;
  endfunction

  typedef logic [NUM_W-1:0] div_num_t;
  typedef logic [DEN_W-1:0] div_den_t;

  typedef struct packed {
    logic [1:0]  data_phy;
    logic [15:0] data_kbps;
    logic [2:0]  ht_mcs;
    logic        short_gi;
    logic        ctrl_phy;
    logic [15:0] ctrl_kbps;
    logic [11:0] frame_bytes;
    logic        is_unicast;
    logic        use_rts;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ack_duration;
    logic [15:0] rts_nav;
    logic [11:0] consume_units;
    logic [11:0] legacy_length;
  } out_item_t;

  // per-frame flags that ride along the divider
  typedef struct packed {
    logic ht;
    logic data_cck;
    logic sgi;
    logic ctrl_cck;
    logic uni;
    logic rts;
  } side_t;

endpackage

// ===== rtl/core/wtad_div_pipe.sv =====
module wtad_div_pipe (
  input  logic              clk_i,
  input  logic              en_i,
  input  wtad_pkg::div_num_t num_i,
  input  wtad_pkg::div_den_t den_i,
  output wtad_pkg::div_num_t quo_o
);
  import wtad_pkg::*;

  logic [DEN_W-1:0] rem_q [DIV_STAGES];
  div_num_t         num_q [DIV_STAGES];
  div_num_t         quo_q [DIV_STAGES];
  div_den_t         den_q [DIV_STAGES];

  // one quotient bit per stage, restoring
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    div_num_t         num_in;
    div_num_t         quo_in;
    div_den_t         den_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign num_in = num_q[g-1];
      assign quo_in = quo_q[g-1];
      assign den_in = den_q[g-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        num_q[g] <= {num_in[NUM_W-2:0], 1'b0};
        quo_q[g] <= {quo_in[NUM_W-2:0], ge};
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// ===== rtl/core/wifi_tx_airtime_duration.sv =====
// Computes ACK duration, RTS/CTS NAV, consume units and HT L-SIG length for
// one transmit frame per transfer. The pipeline takes a new frame every
// cycle while the output is not stalled. Each frame passes through
// one input stage, 25 stages of the bit-per-stage quotient pipelines (frame,
// 14-byte and 20-byte control frames run in parallel), two timing stages and
// the output register. A stalled output freezes the whole pipeline.
// The preamble mode bit must only be written while no frame is in flight.
`include "wifi_tx_airtime_duration_assert.svh"

module wifi_tx_airtime_duration (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wtad_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wtad_pkg::out_item_t  out_data_o
);
  import wtad_pkg::*;

  logic adv;
  logic pre_half_q;

  // input stage
  logic             a_vld_q;
  side_t            a_side_q;
  logic [2:0]       a_mcs_q;
  logic [14:0]      a_bits_q;
  logic [NUM_W-1:0] a_bitsk_q;
  logic [15:0]      a_dk_q, a_ck_q;
  logic [32:0]      a_dkr_q, a_ckr_q;

  logic [11:0] len_sat;
  logic [14:0] bits_d;

  // divider inputs
  div_num_t fr_num, c14_num, c20_num;
  div_den_t fr_den, c_den;
  div_num_t fr_quo, c14_quo, c20_quo;
  div_den_t dd_data, dd_ctrl;
  div_num_t bits_ext;

  // sideband along the divider
  logic  sb_vld_q  [DIV_STAGES];
  side_t sb_side_q [DIV_STAGES];

  // timing stage
  logic              c_vld_q;
  side_t             c_side_q;
  logic [TIME_W-1:0] c_leg_q, c_t14_q, c_t20_q;
  logic [10:0]       c_nsym_q;
  logic [29:0]       c_sgip_q;
  logic [TIME_W-1:0] ovh_cck;
  logic [14:0]       sgi_x;

  // sum stage
  logic              d_vld_q;
  logic              d_ht_q;
  logic [TIME_W-1:0] d_frame_q, d_ack_q, d_nav_q, d_rts_q;
  logic [13:0]       ht_round;
  logic [TIME_W-1:0] ht_time, frame_t, ack_t;

  // output stage
  logic              out_vld_q;
  out_item_t         out_q;
  logic [TIME_W-1:0] consume, units, lsig_l, lsig;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_half_q <= 1'b0;
    end else if (cfg_valid_i) begin
      pre_half_q <= cfg_data_i;
    end
  end

  // input stage: length clamp, bit counts, rate / 250 products
  assign len_sat = (in_data_i.frame_bytes > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES
                                                              : in_data_i.frame_bytes;
  assign bits_d  = {len_sat, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q.ht       <= in_data_i.data_phy == PHY_HT;
      a_side_q.data_cck <= in_data_i.data_phy == PHY_CCK;
      a_side_q.sgi      <= in_data_i.short_gi;
      a_side_q.ctrl_cck <= in_data_i.ctrl_phy == CTRL_CCK;
      a_side_q.uni      <= in_data_i.is_unicast;
      a_side_q.rts      <= in_data_i.use_rts;
      a_mcs_q           <= in_data_i.ht_mcs;
      a_bits_q          <= bits_d;
      a_bitsk_q         <= NUM_W'(bits_d * 10'(KBPS_SCALE));
      a_dk_q            <= in_data_i.data_kbps;
      a_ck_q            <= in_data_i.ctrl_kbps;
      a_dkr_q           <= in_data_i.data_kbps * RECIP_250;
      a_ckr_q           <= in_data_i.ctrl_kbps * RECIP_250;
    end
  end

  // divider operand select
  always_comb begin
    dd_data  = DEN_W'(a_dkr_q[32:RECIP_250_S]);
    dd_ctrl  = DEN_W'(a_ckr_q[32:RECIP_250_S]);
    bits_ext = NUM_W'(a_bits_q);
    if (dd_data == '0) dd_data = DEN_W'(1);
    if (dd_ctrl == '0) dd_ctrl = DEN_W'(1);

    priority if (a_side_q.data_cck) begin
      fr_den = (a_dk_q == '0) ? DEN_W'(1) : a_dk_q;
      fr_num = a_bitsk_q;
    end else if (a_side_q.ht) begin
      fr_den = DEN_W'(ht_dbps(a_mcs_q));
      fr_num = bits_ext + NUM_W'(OFDM_SVC_BITS) + NUM_W'(fr_den) - NUM_W'(1);
    end else begin
      fr_den = dd_data;
      fr_num = bits_ext + NUM_W'(OFDM_SVC_BITS) + NUM_W'(fr_den) - NUM_W'(1);
    end

    if (a_side_q.ctrl_cck) begin
      c_den   = (a_ck_q == '0) ? DEN_W'(1) : a_ck_q;
      c14_num = NUM_W'(ACK_BITS * KBPS_SCALE);
      c20_num = NUM_W'(RTS_BITS * KBPS_SCALE);
    end else begin
      c_den   = dd_ctrl;
      c14_num = NUM_W'(ACK_BITS + OFDM_SVC_BITS) + NUM_W'(c_den) - NUM_W'(1);
      c20_num = NUM_W'(RTS_BITS + OFDM_SVC_BITS) + NUM_W'(c_den) - NUM_W'(1);
    end
  end

  wtad_div_pipe u_div_frame (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (fr_num),
    .den_i (fr_den),
    .quo_o (fr_quo)
  );

  wtad_div_pipe u_div_c14 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c14_num),
    .den_i (c_den),
    .quo_o (c14_quo)
  );

  wtad_div_pipe u_div_c20 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c20_num),
    .den_i (c_den),
    .quo_o (c20_quo)
  );

  // valid and flags alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) sb_vld_q[i] <= 1'b0;
    end else if (adv) begin
      sb_vld_q[0] <= a_vld_q;
      for (int i = 1; i < DIV_STAGES; i++) sb_vld_q[i] <= sb_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_side_q[0] <= a_side_q;
      for (int i = 1; i < DIV_STAGES; i++) sb_side_q[i] <= sb_side_q[i-1];
    end
  end

  // timing stage: legacy times and ht short gi scaling
  assign ovh_cck = pre_half_q ? TIME_W'(CCK_SHORT_OVH) : TIME_W'(CCK_LONG_OVH);
  assign sgi_x   = 15'(fr_quo[10:0] * 5'd18) + 15'd4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= sb_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q <= sb_side_q[DIV_STAGES-1];
      c_leg_q  <= sb_side_q[DIV_STAGES-1].data_cck
                ? ovh_cck + TIME_W'(fr_quo)
                : TIME_W'(OFDM_OVH) + TIME_W'({fr_quo, 2'b00});
      c_t14_q  <= sb_side_q[DIV_STAGES-1].ctrl_cck
                ? ovh_cck + TIME_W'(c14_quo)
                : TIME_W'(OFDM_OVH) + TIME_W'({c14_quo, 2'b00});
      c_t20_q  <= sb_side_q[DIV_STAGES-1].ctrl_cck
                ? ovh_cck + TIME_W'(c20_quo)
                : TIME_W'(OFDM_OVH) + TIME_W'({c20_quo, 2'b00});
      c_nsym_q <= fr_quo[10:0];
      c_sgip_q <= sgi_x * RECIP_5;
    end
  end

  // sum stage: frame time, ack, nav and rts time
  assign ht_round = (14'(c_sgip_q[29:RECIP_5_S]) + 14'd3) & ~14'd3;
  assign ht_time  = (c_side_q.sgi ? TIME_W'(ht_round) : TIME_W'({c_nsym_q, 2'b00}))
                  + TIME_W'(HT_OVH);
  assign frame_t  = c_side_q.ht ? ht_time : c_leg_q;
  assign ack_t    = c_side_q.uni ? c_t14_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_ht_q    <= c_side_q.ht;
      d_frame_q <= frame_t;
      d_ack_q   <= ack_t;
      d_nav_q   <= c_side_q.rts ? frame_t + ack_t + c_t14_q : '0;
      d_rts_q   <= c_side_q.rts ? c_t20_q : '0;
    end
  end

  // output stage: consume units, lsig, saturation
  assign consume = d_nav_q + d_rts_q;
  assign units   = (consume >> 5) + TIME_W'(1);
  assign lsig_l  = (d_frame_q - TIME_W'(LSIG_OFS)) >> 2;
  assign lsig    = d_ht_q ? lsig_l + (lsig_l << 1) - TIME_W'(3) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.ack_duration  <= (d_ack_q > TIME_W'(16'hFFFF)) ? 16'hFFFF : d_ack_q[15:0];
      out_q.rts_nav       <= (d_nav_q > TIME_W'(16'hFFFF)) ? 16'hFFFF : d_nav_q[15:0];
      out_q.consume_units <= (units > TIME_W'(12'hFFF)) ? 12'hFFF : units[11:0];
      out_q.legacy_length <= (lsig > TIME_W'(12'hFFF)) ? 12'hFFF : lsig[11:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // checks
  `WTAD_ASSERT_ALWAYS(a_rst_no_out, clk_i, !rst_ni |-> !out_valid_o)
  `WTAD_ASSERT(a_units_nonzero, clk_i, rst_ni, out_valid_o |-> out_data_o.consume_units != 12'd0)
  `WTAD_ASSERT(a_nav_ge_ack, clk_i, rst_ni, out_valid_o && out_data_o.rts_nav != 16'd0 |-> out_data_o.rts_nav >= out_data_o.ack_duration)
  `WTAD_ASSERT(a_no_rts_unit, clk_i, rst_ni, out_valid_o && out_data_o.rts_nav == 16'd0 |-> out_data_o.consume_units == 12'd1)

endmodule
